// File: src/bfsp_pkg.sv
// ----------------------------------------------------------------------------
// bfsp_pkg: shared types and constants for the shortest-path core
// Field widths, register indexes, vertex record layout and sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bfsp_pkg;

  // parameter defaults
  localparam int MAX_VERTICES_DEF  = 64;
  localparam int EDGE_CAPACITY_DEF = 4096;
  localparam int WEIGHT_BITS_DEF   = 16;

  // fixed field widths
  localparam int VTX_W  = 6;
  localparam int DIST_W = 32;
  localparam int VC_W   = 7;

  // APB register map
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 1;
  localparam logic [REG_IDX_W-1:0] REG_VERTEX_COUNT  = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_SOURCE_VERTEX = 1'd1;

  localparam logic [VC_W-1:0]  VC_RESET  = 7'd64;
  localparam logic [VTX_W-1:0] SRC_RESET = 6'd0;

  localparam logic [DIST_W-1:0] DIST_MAX = 32'h7fff_ffff;
  localparam logic [DIST_W-1:0] DIST_MIN = 32'h8000_0000;

  // one vertex entry of the distance/parent memory
  typedef struct packed {
    logic              reached;
    logic [DIST_W-1:0] dist_val;
    logic              pvalid;
    logic [VTX_W-1:0]  parent;
  } vrec_t;

  localparam vrec_t VREC_UNREACHED = '{reached: 1'b0, dist_val: DIST_MAX,
                                       pvalid: 1'b0, parent: '0};
  localparam vrec_t VREC_SOURCE    = '{reached: 1'b1, dist_val: '0,
                                       pvalid: 1'b0, parent: '0};

  // edge in the compute stage of the relax pipeline
  typedef struct packed {
    logic             valid;
    logic [VTX_W-1:0] u;
    logic [VTX_W-1:0] v;
  } rlx_req_t;

  // write back from the relax unit
  typedef struct packed {
    logic             en;
    logic [VTX_W-1:0] vtx;
    vrec_t            rec;
  } vwr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_RELAX,
    ST_DRAIN,
    ST_OUT_READ,
    ST_OUT_LOAD
  } state_e;

endpackage

// File: src/bfsp_in_if.sv
// ----------------------------------------------------------------------------
// bfsp_in_if: matrix entry channel
// valid/ready handshake carrying one adjacency-matrix entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bfsp_in_if #(
  parameter int WEIGHT_BITS = bfsp_pkg::WEIGHT_BITS_DEF
) ();
  logic                           valid;
  logic                           ready;
  logic [bfsp_pkg::VTX_W-1:0]     from_vertex;
  logic [bfsp_pkg::VTX_W-1:0]     to_vertex;
  logic signed [WEIGHT_BITS-1:0]  weight;
  logic                           last_entry;

  modport source (output valid, from_vertex, to_vertex, weight, last_entry,
                  input ready);
  modport sink   (input valid, from_vertex, to_vertex, weight, last_entry,
                  output ready);
endinterface

// File: src/bfsp_out_if.sv
// ----------------------------------------------------------------------------
// bfsp_out_if: per-vertex result channel
// valid/ready handshake carrying distance, reachability and predecessor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bfsp_out_if ();
  logic                               valid;
  logic                               ready;
  logic [bfsp_pkg::VTX_W-1:0]         vertex;
  logic signed [bfsp_pkg::DIST_W-1:0] distance;
  logic                               reachable;
  logic [bfsp_pkg::VTX_W-1:0]         parent;
  logic                               has_parent;
  logic                               last_vertex;

  modport source (output valid, vertex, distance, reachable, parent, has_parent,
                  last_vertex, input ready);
  modport sink   (input valid, vertex, distance, reachable, parent, has_parent,
                  last_vertex, output ready);
endinterface

// File: src/bfsp_ram.sv
// ----------------------------------------------------------------------------
// bfsp_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];   // old data on same-address collision
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/bfsp_apb_regs.sv
// ----------------------------------------------------------------------------
// bfsp_apb_regs: configuration registers
// vertex_count at 0x0, source_vertex at 0x4; pready is tied high for APB writes and reads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfsp_apb_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bfsp_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [bfsp_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [bfsp_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output logic [bfsp_pkg::VC_W-1:0]           vertex_count_o,
  output logic [bfsp_pkg::VTX_W-1:0]          source_vertex_o
);

  logic [bfsp_pkg::REG_IDX_W-1:0] idx;
  logic                           wr_en;
  logic [bfsp_pkg::VC_W-1:0]      vc_q;
  logic [bfsp_pkg::VTX_W-1:0]     src_q;

  assign idx    = paddr[bfsp_pkg::APB_ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q  <= bfsp_pkg::VC_RESET;
      src_q <= bfsp_pkg::SRC_RESET;
    end else if (wr_en) begin
      case (idx)
        bfsp_pkg::REG_VERTEX_COUNT:  vc_q  <= pwdata[bfsp_pkg::VC_W-1:0];
        bfsp_pkg::REG_SOURCE_VERTEX: src_q <= pwdata[bfsp_pkg::VTX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      bfsp_pkg::REG_VERTEX_COUNT:  prdata = bfsp_pkg::APB_DATA_W'(vc_q);
      bfsp_pkg::REG_SOURCE_VERTEX: prdata = bfsp_pkg::APB_DATA_W'(src_q);
      default:                     prdata = '0;
    endcase
  end

  assign vertex_count_o  = vc_q;
  assign source_vertex_o = src_q;

endmodule

// File: src/bfsp_relax.sv
// ----------------------------------------------------------------------------
// bfsp_relax: edge relaxation stage
// Forwards the previous write-back, saturating add, compare, write decision.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfsp_relax #(
  parameter int MAX_VERTICES = bfsp_pkg::MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = bfsp_pkg::WEIGHT_BITS_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  bfsp_pkg::rlx_req_t                            req_i,
  input  logic signed [WEIGHT_BITS-1:0]                 weight_i,
  input  logic [$clog2(MAX_VERTICES+1)-1:0]             n_i,
  input  bfsp_pkg::vrec_t                               u_rec_i,
  input  bfsp_pkg::vrec_t                               v_rec_i,
  output bfsp_pkg::vwr_t                                wr_o
);

  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int CW = (NW > bfsp_pkg::VTX_W) ? NW : bfsp_pkg::VTX_W;
  localparam int SW = bfsp_pkg::DIST_W + 1;

  logic                       lw_en_q;
  logic [bfsp_pkg::VTX_W-1:0] lw_vtx_q;
  bfsp_pkg::vrec_t            lw_rec_q;

  bfsp_pkg::vrec_t            u_rec, v_rec;
  logic                       u_in, v_in;
  logic [SW-1:0]              sum;
  logic [bfsp_pkg::DIST_W-1:0] cand;
  logic                       better;

  // previous write-back is not yet visible in the read data
  assign u_rec = (lw_en_q && lw_vtx_q == req_i.u) ? lw_rec_q : u_rec_i;
  assign v_rec = (lw_en_q && lw_vtx_q == req_i.v) ? lw_rec_q : v_rec_i;

  assign u_in = CW'(req_i.u) < CW'(n_i);
  assign v_in = CW'(req_i.v) < CW'(n_i);

  assign sum = {u_rec.dist_val[bfsp_pkg::DIST_W-1], u_rec.dist_val}
             + {{(SW-WEIGHT_BITS){weight_i[WEIGHT_BITS-1]}}, weight_i};

  always_comb begin
    if (sum[SW-1] != sum[SW-2]) begin
      cand = sum[SW-1] ? bfsp_pkg::DIST_MIN : bfsp_pkg::DIST_MAX;
    end else begin
      cand = sum[bfsp_pkg::DIST_W-1:0];
    end
  end

  assign better = !v_rec.reached || ($signed(cand) < $signed(v_rec.dist_val));

  always_comb begin
    wr_o.en           = req_i.valid && u_in && v_in && u_rec.reached && better;
    wr_o.vtx          = req_i.v;
    wr_o.rec.reached  = 1'b1;
    wr_o.rec.dist_val = cand;
    wr_o.rec.pvalid   = 1'b1;
    wr_o.rec.parent   = req_i.u;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_en_q <= 1'b0;
    end else begin
      lw_en_q <= wr_o.en;
    end
  end

  always_ff @(posedge clk_i) begin
    lw_vtx_q <= wr_o.vtx;
    lw_rec_q <= wr_o.rec;
  end

endmodule

// File: src/bellman_ford_shortest_paths_core.sv
// ----------------------------------------------------------------------------
// bellman_ford_shortest_paths_core: single-source shortest paths engine
// Load: one matrix entry per cycle while idle; non-zero weights are stored in
// the edge memory, no result per entry. Run after the last entry: clear the
// vertex memory, n passes over the E stored edges (n = vertices; one edge per
// cycle, set by the vertex memory read/write loop), drain, then output results.
// Reset clears control, edge count and registers (vertex_count 64, source 0).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bellman_ford_shortest_paths_core #(
  parameter int MAX_VERTICES  = bfsp_pkg::MAX_VERTICES_DEF,
  parameter int EDGE_CAPACITY = bfsp_pkg::EDGE_CAPACITY_DEF,
  parameter int WEIGHT_BITS   = bfsp_pkg::WEIGHT_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  bfsp_in_if.sink                         in_i,
  bfsp_out_if.source                      res_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bfsp_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [bfsp_pkg::APB_DATA_W-1:0] pwdata,
  output logic [bfsp_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  localparam int VIW  = $clog2(MAX_VERTICES);       // vertex memory address
  localparam int NW   = $clog2(MAX_VERTICES + 1);   // vertex counts
  localparam int CW   = (NW > bfsp_pkg::VC_W) ? NW : bfsp_pkg::VC_W;
  localparam int EAW  = $clog2(EDGE_CAPACITY);
  localparam int CNTW = $clog2(EDGE_CAPACITY + 1);
  localparam int VW   = bfsp_pkg::VTX_W;
  localparam int EW   = 2 * VW + WEIGHT_BITS;       // {from, to, weight}
  localparam int RW   = $bits(bfsp_pkg::vrec_t);

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  logic [bfsp_pkg::VC_W-1:0] vertex_count;
  logic [VW-1:0]             source_vertex;

  bfsp_apb_regs u_regs (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .vertex_count_o  (vertex_count),
    .source_vertex_o (source_vertex)
  );

  // Vertex count clamped to 1..MAX_VERTICES
  logic [CW-1:0] vc_ext;
  logic [NW-1:0] n_cfg;

  assign vc_ext = CW'(vertex_count);

  always_comb begin
    if (vc_ext == '0) begin
      n_cfg = NW'(1);
    end else if (vc_ext > CW'(MAX_VERTICES)) begin
      n_cfg = NW'(MAX_VERTICES);
    end else begin
      n_cfg = NW'(vc_ext);
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer state
  // --------------------------------------------------------------------------
  bfsp_pkg::state_e state_q, state_d;
  logic [NW-1:0]    vi_q, vi_d;       // vertex index for clear and output
  logic [NW-1:0]    pass_q, pass_d;
  logic [EAW-1:0]   edge_q, edge_d;
  logic [CNTW-1:0]  cnt_q, cnt_d;     // stored edges
  logic [NW-1:0]    n_q, n_d;         // vertices in this run

  logic in_ready, in_acc, store_edge;
  logic edge_we, issue, clr_we, out_rd, out_load;
  logic vi_last, pass_last, edge_last;

  logic b_valid_q, c_valid_q;         // relax pipeline occupancy
  logic out_valid_q;

  assign in_ready   = (state_q == bfsp_pkg::ST_IDLE);
  assign in_i.ready = in_ready;
  assign in_acc     = in_i.valid & in_ready;
  // zero weight means no edge; a full edge memory drops the entry
  assign store_edge = (in_i.weight != '0) && (cnt_q != CNTW'(EDGE_CAPACITY));

  assign vi_last   = (vi_q + NW'(1)) == n_q;
  assign pass_last = (pass_q + NW'(1)) == n_q;
  assign edge_last = (CNTW'(edge_q) + CNTW'(1)) == cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfsp_pkg::ST_IDLE;
      vi_q    <= '0;
      pass_q  <= '0;
      edge_q  <= '0;
      cnt_q   <= '0;
      n_q     <= NW'(1);
    end else begin
      state_q <= state_d;
      vi_q    <= vi_d;
      pass_q  <= pass_d;
      edge_q  <= edge_d;
      cnt_q   <= cnt_d;
      n_q     <= n_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    vi_d     = vi_q;
    pass_d   = pass_q;
    edge_d   = edge_q;
    cnt_d    = cnt_q;
    n_d      = n_q;
    edge_we  = 1'b0;
    issue    = 1'b0;
    clr_we   = 1'b0;
    out_rd   = 1'b0;
    out_load = 1'b0;
    case (state_q)
      bfsp_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (store_edge) begin
            edge_we = 1'b1;
            cnt_d   = cnt_q + CNTW'(1);
          end
          if (in_i.last_entry) begin
            n_d     = n_cfg;
            vi_d    = '0;
            state_d = bfsp_pkg::ST_CLEAR;
          end
        end
      end
      // one vertex entry per cycle: unreached, or distance 0 for the source
      bfsp_pkg::ST_CLEAR: begin
        clr_we = 1'b1;
        if (vi_last) begin
          vi_d = '0;
          if (cnt_q == '0) begin
            state_d = bfsp_pkg::ST_OUT_READ;
          end else begin
            pass_d  = '0;
            edge_d  = '0;
            state_d = bfsp_pkg::ST_RELAX;
          end
        end else begin
          vi_d = vi_q + NW'(1);
        end
      end
      // issue one edge read per cycle over n passes
      bfsp_pkg::ST_RELAX: begin
        issue = 1'b1;
        if (edge_last) begin
          edge_d = '0;
          if (pass_last) begin
            state_d = bfsp_pkg::ST_DRAIN;
          end else begin
            pass_d = pass_q + NW'(1);
          end
        end else begin
          edge_d = edge_q + EAW'(1);
        end
      end
      bfsp_pkg::ST_DRAIN: begin
        if (!b_valid_q && !c_valid_q) begin
          vi_d    = '0;
          state_d = bfsp_pkg::ST_OUT_READ;
        end
      end
      bfsp_pkg::ST_OUT_READ: begin
        out_rd  = 1'b1;
        state_d = bfsp_pkg::ST_OUT_LOAD;
      end
      bfsp_pkg::ST_OUT_LOAD: begin
        out_rd = 1'b1;
        if (!out_valid_q || res_o.ready) begin
          out_load = 1'b1;
          if (vi_last) begin
            cnt_d   = '0;               // edge memory emptied for next matrix
            state_d = bfsp_pkg::ST_IDLE;
          end else begin
            vi_d    = vi_q + NW'(1);
            state_d = bfsp_pkg::ST_OUT_READ;
          end
        end
      end
      default: begin
        state_d = bfsp_pkg::ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Edge memory: {from, to, weight} in arrival order
  // --------------------------------------------------------------------------
  logic [EW-1:0] edge_wdata, edge_rdata;

  assign edge_wdata = {in_i.from_vertex, in_i.to_vertex, in_i.weight};

  bfsp_ram #(
    .WIDTH (EW),
    .DEPTH (EDGE_CAPACITY)
  ) u_edge_mem (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (cnt_q[EAW-1:0]),
    .wdata_i (edge_wdata),
    .raddr_i (edge_q),
    .rdata_o (edge_rdata)
  );

  // --------------------------------------------------------------------------
  // Relax pipeline
  //   A: edge address issued      B: edge data -> vertex reads of u and v
  //   C: vertex data -> compute and write back (forwarding covers C -> C)
  // --------------------------------------------------------------------------
  logic [VW-1:0]                 e_from, e_to;
  logic signed [WEIGHT_BITS-1:0] e_w;
  logic [VW-1:0]                 c_u_q, c_v_q;
  logic signed [WEIGHT_BITS-1:0] c_w_q;

  assign e_from = edge_rdata[EW-1 -: VW];
  assign e_to   = edge_rdata[WEIGHT_BITS +: VW];
  assign e_w    = edge_rdata[WEIGHT_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      b_valid_q <= issue;
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c_u_q <= e_from;
    c_v_q <= e_to;
    c_w_q <= e_w;
  end

  // --------------------------------------------------------------------------
  // Vertex memory: two copies written together give reads of u and v
  // --------------------------------------------------------------------------
  bfsp_pkg::rlx_req_t req;
  bfsp_pkg::vwr_t     rlx_wr;
  bfsp_pkg::vrec_t    va_rdata, vb_rdata, v_wdata;
  logic [RW-1:0]      va_raw, vb_raw;
  logic               v_we;
  logic [VIW-1:0]     v_waddr, va_raddr;

  assign va_rdata = va_raw;
  assign vb_rdata = vb_raw;

  assign req.valid = c_valid_q;
  assign req.u     = c_u_q;
  assign req.v     = c_v_q;

  bfsp_relax #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_relax (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req),
    .weight_i (c_w_q),
    .n_i      (n_q),
    .u_rec_i  (va_rdata),
    .v_rec_i  (vb_rdata),
    .wr_o     (rlx_wr)
  );

  always_comb begin
    if (clr_we) begin
      v_we    = 1'b1;
      v_waddr = VIW'(vi_q);
      v_wdata = (CW'(vi_q) == CW'(source_vertex)) ? bfsp_pkg::VREC_SOURCE
                                                   : bfsp_pkg::VREC_UNREACHED;
    end else begin
      v_we    = rlx_wr.en;
      v_waddr = VIW'(rlx_wr.vtx);
      v_wdata = rlx_wr.rec;
    end
  end

  assign va_raddr = out_rd ? VIW'(vi_q) : VIW'(e_from);

  bfsp_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_VERTICES)
  ) u_vtx_mem_a (
    .clk_i   (clk_i),
    .we_i    (v_we),
    .waddr_i (v_waddr),
    .wdata_i (v_wdata),
    .raddr_i (va_raddr),
    .rdata_o (va_raw)
  );

  bfsp_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_VERTICES)
  ) u_vtx_mem_b (
    .clk_i   (clk_i),
    .we_i    (v_we),
    .waddr_i (v_waddr),
    .wdata_i (v_wdata),
    .raddr_i (VIW'(e_to)),
    .rdata_o (vb_raw)
  );

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  bfsp_pkg::vrec_t out_rec_q;
  logic [VW-1:0]   out_vtx_q;
  logic            out_last_q;
  logic            out_hp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_rec_q  <= va_rdata;
      out_vtx_q  <= VW'(vi_q);
      out_last_q <= vi_last;
    end
  end

  assign out_hp = out_rec_q.reached & out_rec_q.pvalid;

  assign res_o.valid       = out_valid_q;
  assign res_o.vertex      = out_vtx_q;
  assign res_o.distance    = out_rec_q.reached ? out_rec_q.dist_val : bfsp_pkg::DIST_MAX;
  assign res_o.reachable   = out_rec_q.reached;
  assign res_o.parent      = out_hp ? out_rec_q.parent : '0;
  assign res_o.has_parent  = out_hp;
  assign res_o.last_vertex = out_last_q;

endmodule
